@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// Assertion macros used by the RTL. Under SYNTH they expand to nothing.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Checks that prop holds at every rising edge of clk while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("assertion failed");
// Checks that cond is never true at a rising edge of clk while out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

@@ src/rcsa_pkg.sv @@
// ----------------------------------------------------------------------------
// rcsa_pkg
// Types and constants of the remote command sequence arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package rcsa_pkg;

  localparam logic [15:0]        RPM_SLOW   = 16'd60;
  localparam logic [15:0]        RPM_FAST   = 16'd100;
  localparam logic signed [7:0]  ANGLE_MIN  = -8'sd30;
  localparam logic signed [7:0]  ANGLE_MAX  = 8'sd30;
  localparam logic [15:0]        HALF_RANGE = 16'h8000;
  localparam logic [31:0]        TIMEOUT_RESET = 32'd1000;

  typedef enum logic [1:0] {
    CMD_FRAME      = 2'd0,
    CMD_TICK       = 2'd1,
    CMD_DISCONNECT = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    MV_STOP    = 2'd0,
    MV_FORWARD = 2'd1,
    MV_REVERSE = 2'd2,
    MV_OTHER   = 2'd3
  } move_t;

  typedef enum logic [1:0] {
    TN_CENTER  = 2'd0,
    TN_LEFT    = 2'd1,
    TN_RIGHT   = 2'd2,
    TN_INVALID = 2'd3
  } turn_t;

  typedef enum logic [1:0] {
    DEC_NEW     = 2'd0,
    DEC_DUP     = 2'd1,
    DEC_REJECT  = 2'd2,
    DEC_NOT_CMD = 2'd3
  } decision_t;

  typedef enum logic [2:0] {
    ERR_NONE      = 3'd0,
    ERR_RANGE     = 3'd1,
    ERR_SEMANTIC  = 3'd2,
    ERR_REVERSE   = 3'd3,
    ERR_STEPPER   = 3'd4,
    ERR_CONFLICT  = 3'd5,
    ERR_AMBIGUOUS = 3'd6,
    ERR_OLD       = 3'd7
  } err_t;

  typedef enum logic [1:0] {
    REG_REVERSE_FORBIDDEN = 2'd0,
    REG_STEPPER_CONFIRMED = 2'd1,
    REG_LINK_TIMEOUT      = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [15:0]       sequence_req;
    logic [1:0]        move;
    logic [1:0]        turn;
    logic [15:0]       stepper_speed;
    logic signed [7:0] servo_angle;
    logic [31:0]       now_ms;
  } item_t;

  typedef struct packed {
    decision_t   decision;
    err_t        error_code;
    logic        timed_out;
    logic        link_up;
    logic [31:0] gap_count;
    logic [15:0] held_sequence;
  } result_t;

  typedef struct packed {
    logic        reverse_forbidden;
    logic        stepper_confirmed;
    logic [31:0] link_timeout_ms;
  } cfg_t;

  // Handshake between the input stage and the core.
  typedef struct packed {
    logic take;
  } stage_ctl_t;

endpackage

`default_nettype wire

@@ src/rcsa_in_reg.sv @@
// ----------------------------------------------------------------------------
// rcsa_in_reg
// Input register stage: holds one item until the core takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rcsa_in_reg (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rcsa_pkg::item_t in_item,
  input  wire logic            take,
  output logic                 stage_valid,
  output rcsa_pkg::item_t      stage_item
);
  import rcsa_pkg::*;

  logic  valid_r;
  item_t item_r;

  // The stage frees up in the same cycle the core takes its item.
  assign in_ready    = !valid_r || take;
  assign stage_valid = valid_r;
  assign stage_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

endmodule

`default_nettype wire

@@ src/rcsa_core.sv @@
// ----------------------------------------------------------------------------
// rcsa_core
// Validation, sequence classification, link state and the result register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module rcsa_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire rcsa_pkg::cfg_t     cfg,
  input  wire logic               stage_valid,
  input  wire rcsa_pkg::item_t    stage_item,
  output rcsa_pkg::stage_ctl_t    ctl,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output rcsa_pkg::result_t       result
);
  import rcsa_pkg::*;

  // Link and window state
  logic        window_valid_r, window_valid_nxt;
  logic        alive_r, alive_nxt;
  logic [15:0] last_seq_r, last_seq_nxt;
  logic [1:0]  last_move_r, last_move_nxt;
  logic [1:0]  last_turn_r, last_turn_nxt;
  logic [15:0] last_rpm_r, last_rpm_nxt;
  logic [7:0]  last_angle_r, last_angle_nxt;
  logic [31:0] last_time_r, last_time_nxt;
  logic [31:0] gaps_r, gaps_nxt;

  logic        out_valid_r;
  result_t     res_r, res_nxt;

  logic        take;
  err_t        check_err;
  logic        range_ok;
  logic        turn_ok;
  logic [15:0] delta;
  logic [31:0] silence;
  logic        same_payload;
  decision_t   dec;
  err_t        err;
  logic        expired;

  assign take      = stage_valid && (!out_valid_r || out_ready);
  assign ctl.take  = take;
  assign out_valid = out_valid_r;
  assign result    = res_r;

  // Range and semantic checks of a command frame.
  always_comb begin
    range_ok = (stage_item.stepper_speed == RPM_SLOW ||
                stage_item.stepper_speed == RPM_FAST) &&
               (stage_item.servo_angle >= ANGLE_MIN) &&
               (stage_item.servo_angle <= ANGLE_MAX);
    unique case (stage_item.turn)
      TN_LEFT:   turn_ok = stage_item.servo_angle < 8'sd0;
      TN_RIGHT:  turn_ok = stage_item.servo_angle > 8'sd0;
      TN_CENTER: turn_ok = stage_item.servo_angle == 8'sd0;
      default:   turn_ok = 1'b0;
    endcase
    priority if (!range_ok) begin
      check_err = ERR_RANGE;
    end else if (!turn_ok) begin
      check_err = ERR_SEMANTIC;
    end else if (stage_item.move == MV_REVERSE && cfg.reverse_forbidden) begin
      check_err = ERR_REVERSE;
    end else if ((stage_item.move == MV_FORWARD || stage_item.move == MV_REVERSE) &&
                 !cfg.stepper_confirmed) begin
      check_err = ERR_STEPPER;
    end else begin
      check_err = ERR_NONE;
    end
  end

  assign delta   = stage_item.sequence_req - last_seq_r;
  assign silence = stage_item.now_ms - last_time_r;
  assign same_payload = (stage_item.move == last_move_r) &&
                        (stage_item.turn == last_turn_r) &&
                        (stage_item.stepper_speed == last_rpm_r) &&
                        (stage_item.servo_angle == last_angle_r);

  always_comb begin
    window_valid_nxt = window_valid_r;
    alive_nxt        = alive_r;
    last_seq_nxt     = last_seq_r;
    last_move_nxt    = last_move_r;
    last_turn_nxt    = last_turn_r;
    last_rpm_nxt     = last_rpm_r;
    last_angle_nxt   = last_angle_r;
    last_time_nxt    = last_time_r;
    gaps_nxt         = gaps_r;
    dec              = DEC_NOT_CMD;
    err              = ERR_NONE;
    expired          = 1'b0;

    unique case (stage_item.cmd)
      CMD_FRAME: begin
        priority if (check_err != ERR_NONE) begin
          dec = DEC_REJECT;
          err = check_err;
        end else if (!window_valid_r) begin
          dec = DEC_NEW;
        end else if (delta == 16'd0) begin
          if (same_payload) begin
            dec = DEC_DUP;
          end else begin
            dec = DEC_REJECT;
            err = ERR_CONFLICT;
          end
        end else if (delta == HALF_RANGE) begin
          dec = DEC_REJECT;
          err = ERR_AMBIGUOUS;
        end else if (delta > HALF_RANGE) begin
          dec = DEC_REJECT;
          err = ERR_OLD;
        end else begin
          dec = DEC_NEW;
        end

        if (dec == DEC_NEW) begin
          if (window_valid_r && delta > 16'd1) begin
            gaps_nxt = gaps_r + 32'd1;
          end
          window_valid_nxt = 1'b1;
          alive_nxt        = 1'b1;
          last_seq_nxt     = stage_item.sequence_req;
          last_move_nxt    = stage_item.move;
          last_turn_nxt    = stage_item.turn;
          last_rpm_nxt     = stage_item.stepper_speed;
          last_angle_nxt   = stage_item.servo_angle;
          last_time_nxt    = stage_item.now_ms;
        end else if (dec == DEC_DUP) begin
          alive_nxt     = 1'b1;
          last_time_nxt = stage_item.now_ms;
        end
      end
      CMD_TICK: begin
        if (alive_r && silence >= cfg.link_timeout_ms) begin
          alive_nxt        = 1'b0;
          window_valid_nxt = 1'b0;
          expired          = 1'b1;
        end
      end
      CMD_DISCONNECT: begin
        alive_nxt        = 1'b0;
        window_valid_nxt = 1'b0;
      end
      default: begin
        // Unused command code: no effect.
      end
    endcase

    res_nxt.decision      = dec;
    res_nxt.error_code    = err;
    res_nxt.timed_out     = expired;
    res_nxt.link_up       = alive_nxt;
    res_nxt.gap_count     = gaps_nxt;
    res_nxt.held_sequence = last_seq_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_valid_r <= 1'b0;
      alive_r        <= 1'b0;
      last_seq_r     <= '0;
      last_move_r    <= '0;
      last_turn_r    <= '0;
      last_rpm_r     <= '0;
      last_angle_r   <= '0;
      last_time_r    <= '0;
      gaps_r         <= '0;
    end else if (take) begin
      window_valid_r <= window_valid_nxt;
      alive_r        <= alive_nxt;
      last_seq_r     <= last_seq_nxt;
      last_move_r    <= last_move_nxt;
      last_turn_r    <= last_turn_nxt;
      last_rpm_r     <= last_rpm_nxt;
      last_angle_r   <= last_angle_nxt;
      last_time_r    <= last_time_nxt;
      gaps_r         <= gaps_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_r <= res_nxt;
    end
  end

  `ASSERT_CLK(a_gaps_step, clk, rst_n, ##1 (gaps_r == $past(gaps_r) || gaps_r == $past(gaps_r) + 32'd1))
  `ASSERT_NEVER(a_window_without_link, clk, rst_n, window_valid_r && !alive_r)
  `ASSERT_CLK(a_new_raises_link, clk, rst_n, (take && dec == DEC_NEW) |=> (alive_r && last_seq_r == res_r.held_sequence))
  `ASSERT_CLK(a_reject_has_code, clk, rst_n, (out_valid_r && res_r.decision == DEC_REJECT) |-> (res_r.error_code != ERR_NONE))
  `ASSERT_CLK(a_timeout_drops, clk, rst_n, (out_valid_r && res_r.timed_out) |-> (!res_r.link_up && res_r.decision == DEC_NOT_CMD))

endmodule

`default_nettype wire

@@ src/remote_command_sequence_arbiter.sv @@
// ----------------------------------------------------------------------------
// remote_command_sequence_arbiter
// Checks remote motion commands, filters them by 16-bit serial number
// order and keeps the link alive state driven by frames, ticks and disconnects.
//
//   Channel  Direction  Handshake             Payload
//   in_      input      in_valid / in_ready   cmd, sequence, motion, now_ms
//   out_     output     out_valid / out_ready decision, error, link, counters
//   cfg_     input      cfg_we                cfg_index, cfg_data
//
// One item per cycle sustained while out_ready is high; a result passes
// through the input register, then the result register, before it is
// presented.
// Command state is updated in the same cycle an item moves to the result
// register, so the next item always sees it. Stalls on out_ready back up
// through the input stage. Reset is synchronous.
// ----------------------------------------------------------------------------
`default_nettype none

module remote_command_sequence_arbiter (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  // input channel
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_cmd,
  input  wire logic [15:0]        in_sequence_req,
  input  wire logic [1:0]         in_move,
  input  wire logic [1:0]         in_turn,
  input  wire logic [15:0]        in_stepper_speed,
  input  wire logic signed [7:0]  in_servo_angle,
  input  wire logic [31:0]        in_now_ms,
  // result channel
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_decision,
  output logic [2:0]              out_error_code,
  output logic                    out_timed_out,
  output logic                    out_link_up,
  output logic [31:0]             out_gap_count,
  output logic [15:0]             out_held_sequence
);
  import rcsa_pkg::*;

  cfg_t       cfg_r;
  item_t      in_item;
  item_t      stage_item;
  logic       stage_valid;
  stage_ctl_t ctl;
  result_t    result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.reverse_forbidden <= 1'b1;
      cfg_r.stepper_confirmed <= 1'b0;
      cfg_r.link_timeout_ms   <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_REVERSE_FORBIDDEN: cfg_r.reverse_forbidden <= cfg_data[0];
        REG_STEPPER_CONFIRMED: cfg_r.stepper_confirmed <= cfg_data[0];
        REG_LINK_TIMEOUT:      cfg_r.link_timeout_ms   <= cfg_data;
        default: begin
          // Writes to unknown indexes are dropped.
        end
      endcase
    end
  end

  always_comb begin
    in_item.cmd           = in_cmd;
    in_item.sequence_req  = in_sequence_req;
    in_item.move          = in_move;
    in_item.turn          = in_turn;
    in_item.stepper_speed = in_stepper_speed;
    in_item.servo_angle   = in_servo_angle;
    in_item.now_ms        = in_now_ms;
  end

  rcsa_in_reg u_in_reg (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .take        (ctl.take),
    .stage_valid (stage_valid),
    .stage_item  (stage_item)
  );

  rcsa_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg_r),
    .stage_valid (stage_valid),
    .stage_item  (stage_item),
    .ctl         (ctl),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result)
  );

  assign out_decision      = result.decision;
  assign out_error_code    = result.error_code;
  assign out_timed_out     = result.timed_out;
  assign out_link_up       = result.link_up;
  assign out_gap_count     = result.gap_count;
  assign out_held_sequence = result.held_sequence;

endmodule

`default_nettype wire
